// File: sv/khle_pkg.sv
// Package for the keyed hex list extractor: field widths, character codes,
// the parser phase type and the hex digit decoder. No dependencies.
`default_nettype none

package khle_pkg;

   localparam int TEXT_W   = 8;
   localparam int VALUE_W  = 28;
   localparam int COUNT_W  = 5;
   localparam int DIGIT_W  = 3;
   localparam int NIBBLE_W = 4;

   localparam logic [DIGIT_W-1:0] MAX_DIGITS = 3'd7;
   localparam logic [COUNT_W-1:0] LIST_CAP   = 5'd16;
   localparam logic [COUNT_W-1:0] MAX_VALUES_RESET = 5'd16;

   localparam logic [TEXT_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [TEXT_W-1:0] CHAR_SIX   = 8'h36;
   localparam logic [TEXT_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [TEXT_W-1:0] CHAR_OPEN  = 8'h28;
   localparam logic [TEXT_W-1:0] CHAR_CLOSE = 8'h29;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_LIST,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic                is_digit;
      logic [NIBBLE_W-1:0] nibble;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [TEXT_W-1:0] c);
      hex_digit_type r;
      r.is_digit = 1'b0;
      r.nibble   = '0;
      case (c) inside
         [8'h30:8'h39]: begin
            r.is_digit = 1'b1;
            r.nibble   = c[NIBBLE_W-1:0];
         end
         [8'h41:8'h46], [8'h61:8'h66]: begin
            r.is_digit = 1'b1;
            r.nibble   = c[NIBBLE_W-1:0] + 4'd9;
         end
         default: begin
            r.is_digit = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/khle_if.sv
// Channel interfaces of the keyed hex list extractor: request, response and
// register write. Depends on khle_pkg for the field widths.
`default_nettype none

interface khle_req_if;
   logic                          valid;
   logic                          ready;
   logic [khle_pkg::TEXT_W-1:0]   text_byte;
   logic                          string_start;
   modport source (output valid, text_byte, string_start, input ready);
   modport sink   (input valid, text_byte, string_start, output ready);
endinterface

interface khle_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [khle_pkg::VALUE_W-1:0]  value;
   logic                          value_valid;
   logic                          done_res;
   logic [khle_pkg::COUNT_W-1:0]  stored_count;
   modport source (output valid, value, value_valid, done_res, stored_count, input ready);
   modport sink   (input valid, value, value_valid, done_res, stored_count, output ready);
endinterface

interface khle_csr_if;
   logic                          valid;
   logic                          ready;
   logic [khle_pkg::COUNT_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/keyed_hex_list_extractor.sv
// Keyed hex list extractor: one text byte per transaction, parser state and
// a registered response stage. Depends on khle_pkg and the khle_*_if channels.
// Response valid rises in the cycle after a storing or final byte; one byte is
// taken every cycle while the response register is empty or being drained.
// Synchronous active-high reset clears the parser and sets max_values to 16.
`default_nettype none

module keyed_hex_list_extractor (
   input  wire logic   clock,
   input  wire logic   reset,
   khle_req_if.sink    req_ch,
   khle_rsp_if.source  rsp_ch,
   khle_csr_if.sink    csr_ch
);
   import khle_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [TEXT_W-1:0]    prev_ff, prev_in;
   logic [TEXT_W-1:0]    pprev_ff, pprev_in;
   logic [VALUE_W-1:0]   accum_ff, accum_in;
   logic [DIGIT_W-1:0]   digits_ff, digits_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   max_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic                 stored_ff, stored_in;
   logic                 done_ff, done_in;
   logic [COUNT_W-1:0]   scount_ff;

   logic                 accept;
   logic [COUNT_W-1:0]   limit;
   hex_digit_type        hd;
   phase_type            ph_cur;
   logic [TEXT_W-1:0]    c, prev_cur, pprev_cur;
   logic [VALUE_W-1:0]   accum_cur;
   logic [DIGIT_W-1:0]   digits_cur;
   logic [COUNT_W-1:0]   count_cur;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign limit        = (max_ff < LIST_CAP) ? max_ff : LIST_CAP;
   assign c            = req_ch.text_byte;
   assign hd           = hex_decode(c);

   always_comb begin
      ph_cur     = req_ch.string_start ? PH_SEARCH : phase_ff;
      prev_cur   = req_ch.string_start ? '0 : prev_ff;
      pprev_cur  = req_ch.string_start ? '0 : pprev_ff;
      accum_cur  = req_ch.string_start ? '0 : accum_ff;
      digits_cur = req_ch.string_start ? '0 : digits_ff;
      count_cur  = req_ch.string_start ? '0 : count_ff;

      phase_in  = ph_cur;
      prev_in   = prev_cur;
      pprev_in  = pprev_cur;
      accum_in  = accum_cur;
      digits_in = digits_cur;
      count_in  = count_cur;
      value_in  = '0;
      stored_in = 1'b0;
      done_in   = 1'b0;

      case (ph_cur)
         PH_SEARCH: begin
            if (c == CHAR_NUL) begin
               done_in  = 1'b1;
               phase_in = PH_DONE;
            end else if (c == CHAR_OPEN && prev_cur == CHAR_ZERO
                         && pprev_cur == CHAR_SIX) begin
               phase_in  = PH_LIST;
               accum_in  = '0;
               digits_in = '0;
            end else begin
               pprev_in = prev_cur;
               prev_in  = c;
            end
         end
         PH_LIST: begin
            if (hd.is_digit) begin
               if (digits_cur < MAX_DIGITS) begin
                  accum_in  = {accum_cur[VALUE_W-NIBBLE_W-1:0], hd.nibble};
                  digits_in = digits_cur + 1'b1;
               end
            end else begin
               if (digits_cur != '0 && count_cur < limit) begin
                  value_in  = accum_cur;
                  count_in  = count_cur + 1'b1;
                  stored_in = 1'b1;
               end
               accum_in  = '0;
               digits_in = '0;
               if (c == CHAR_CLOSE || c == CHAR_NUL) begin
                  done_in  = 1'b1;
                  phase_in = PH_DONE;
               end
            end
         end
         default: begin
            phase_in = ph_cur;
         end
      endcase

      if (accept) begin
         rsp_valid_in = stored_in || done_in;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         prev_ff      <= '0;
         pprev_ff     <= '0;
         accum_ff     <= '0;
         digits_ff    <= '0;
         count_ff     <= '0;
         max_ff       <= MAX_VALUES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            max_ff <= csr_ch.data;
         end
         if (accept) begin
            phase_ff  <= phase_in;
            prev_ff   <= prev_in;
            pprev_ff  <= pprev_in;
            accum_ff  <= accum_in;
            digits_ff <= digits_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff  <= value_in;
         stored_ff <= stored_in;
         done_ff   <= done_in;
         scount_ff <= count_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.value        = value_ff;
   assign rsp_ch.value_valid  = stored_ff;
   assign rsp_ch.done_res     = done_ff;
   assign rsp_ch.stored_count = scount_ff;

endmodule

`default_nettype wire
